@@ rtl/core/tsmc_pkg.sv @@
`timescale 1ns / 1ps

package tsmc_pkg;

    localparam int SAMPLE_W = 13;
    localparam int SUM_W    = SAMPLE_W + 1;
    localparam int GAIN_W   = 21;
    localparam int OFFSET_W = 27;
    localparam int REF_W    = 12;
    localparam int POINT_W  = 16;
    localparam int PROD_W   = 36;
    localparam int DIFF_W   = 38;
    localparam int FRAC_W   = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;

    localparam logic signed [GAIN_W-1:0]   GAIN_X_RESET   = -21'sd4325;
    localparam logic signed [OFFSET_W-1:0] OFFSET_X_RESET = 27'sd16869171;
    localparam logic signed [GAIN_W-1:0]   GAIN_Y_RESET   = 21'sd5898;
    localparam logic signed [OFFSET_W-1:0] OFFSET_Y_RESET = -27'sd1179648;
    localparam logic [SAMPLE_W-1:0]        SPREAD_RESET   = 13'd100;
    localparam logic [REF_W-1:0]           X_REF_RESET    = 12'd240;
    localparam logic [REF_W-1:0]           Y_REF_RESET    = 12'd320;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_X   = 3'd0,
        CFG_OFFSET_X = 3'd1,
        CFG_GAIN_Y   = 3'd2,
        CFG_OFFSET_Y = 3'd3,
        CFG_SPREAD   = 3'd4,
        CFG_X_REF    = 3'd5,
        CFG_Y_REF    = 3'd6
    } tsmc_cfg_idx_t;

    typedef struct packed {
        logic                pressed;
        logic [SAMPLE_W-1:0] x_sample_a;
        logic [SAMPLE_W-1:0] x_sample_b;
        logic [SAMPLE_W-1:0] x_sample_c;
        logic [SAMPLE_W-1:0] x_sample_d;
        logic [SAMPLE_W-1:0] y_sample_a;
        logic [SAMPLE_W-1:0] y_sample_b;
        logic [SAMPLE_W-1:0] y_sample_c;
        logic [SAMPLE_W-1:0] y_sample_d;
    } tsmc_in_t;

    typedef struct packed {
        logic                       touch_state;
        logic signed [POINT_W-1:0]  point_x;
        logic signed [POINT_W-1:0]  point_y;
    } tsmc_out_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0]   gain;
        logic signed [OFFSET_W-1:0] offset;
        logic [REF_W-1:0]           reference;
    } tsmc_axis_cfg_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } tsmc_stage_en_t;

endpackage

@@ rtl/core/tsmc_sort4.sv @@
`timescale 1ns / 1ps

module tsmc_sort4
    import tsmc_pkg::*;
(
    input  logic [3:0][SAMPLE_W-1:0] samples,
    output logic [SAMPLE_W-1:0]      mid_lo,
    output logic [SAMPLE_W-1:0]      mid_hi
);

    logic [SAMPLE_W-1:0] a0, a1, a2, a3;
    logic [SAMPLE_W-1:0] b1, b2;

    // three-level network, only the middle pair is kept
    always_comb
    begin
        a0 = (samples[0] < samples[1]) ? samples[0] : samples[1];
        a1 = (samples[0] < samples[1]) ? samples[1] : samples[0];
        a2 = (samples[2] < samples[3]) ? samples[2] : samples[3];
        a3 = (samples[2] < samples[3]) ? samples[3] : samples[2];
        b2 = (a0 < a2) ? a2 : a0;
        b1 = (a1 < a3) ? a1 : a3;
        mid_lo = (b1 < b2) ? b1 : b2;
        mid_hi = (b1 < b2) ? b2 : b1;
    end

endmodule

@@ rtl/core/tsmc_axis_lane.sv @@
`timescale 1ns / 1ps

module tsmc_axis_lane
    import tsmc_pkg::*;
(
    input  logic                      clk,
    input  tsmc_stage_en_t            en,
    input  logic [3:0][SAMPLE_W-1:0]  samples,
    input  logic [SAMPLE_W-1:0]       spread_limit,
    input  tsmc_axis_cfg_t            cfg,
    output logic signed [POINT_W-1:0] coord,
    output logic                      ok
);

    logic [SAMPLE_W-1:0]       mid_lo;
    logic [SAMPLE_W-1:0]       mid_hi;

    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic                      ok1_reg, ok1_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic                      ok2_reg;
    logic signed [POINT_W-1:0] coord_reg, coord_next;
    logic                      ok3_reg;

    logic signed [DIFF_W-1:0]  term;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [DIFF_W-1:0]  diff_adj;
    logic signed [DIFF_W-FRAC_W-1:0] quot;

    tsmc_sort4 u_sort
    (
        .samples (samples),
        .mid_lo  (mid_lo),
        .mid_hi  (mid_hi)
    );

    always_comb
    begin
        sum_next = {1'b0, mid_lo} + {1'b0, mid_hi};
        ok1_next = (mid_lo != '0) && (mid_hi != '0) && ((mid_hi - mid_lo) <= spread_limit);
    end

    assign prod_next = $signed({1'b0, sum_reg}) * cfg.gain;

    // reference*2^17 - (sum*gain + 2*offset), divided by 2^17 truncating toward zero, then saturated
    always_comb
    begin
        term = {{(DIFF_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg}
             + {{(DIFF_W-OFFSET_W-1){cfg.offset[OFFSET_W-1]}}, cfg.offset, 1'b0};
        diff = $signed({{(DIFF_W-REF_W-FRAC_W){1'b0}}, cfg.reference, {FRAC_W{1'b0}}}) - term;
        diff_adj = diff[DIFF_W-1] ? diff + DIFF_W'((1 << FRAC_W) - 1) : diff;
        quot = diff_adj[DIFF_W-1:FRAC_W];
        if ((quot[DIFF_W-FRAC_W-1:POINT_W-1] == '0)
            || (quot[DIFF_W-FRAC_W-1:POINT_W-1] == '1))
        begin
            coord_next = quot[POINT_W-1:0];
        end
        else if (quot[DIFF_W-FRAC_W-1])
        begin
            coord_next = {1'b1, {(POINT_W-1){1'b0}}};
        end
        else
        begin
            coord_next = {1'b0, {(POINT_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            sum_reg <= sum_next;
            ok1_reg <= ok1_next;
        end
        if (en.s2)
        begin
            prod_reg <= prod_next;
            ok2_reg  <= ok1_reg;
        end
        if (en.s3)
        begin
            coord_reg <= coord_next;
            ok3_reg   <= ok2_reg;
        end
    end

    assign coord = coord_reg;
    assign ok    = ok3_reg;

endmodule

@@ rtl/core/tsmc_merge.sv @@
`timescale 1ns / 1ps

module tsmc_merge
    import tsmc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  logic                      pressed,
    input  logic signed [POINT_W-1:0] x_coord,
    input  logic                      x_ok,
    input  logic signed [POINT_W-1:0] y_coord,
    input  logic                      y_ok,
    output tsmc_out_t                 result
);

    logic signed [POINT_W-1:0] held_x_reg, held_x_next;
    logic signed [POINT_W-1:0] held_y_reg, held_y_next;
    tsmc_out_t                 result_reg, result_next;

    always_comb
    begin
        if (pressed && x_ok && y_ok)
        begin
            held_x_next = x_coord;
            held_y_next = y_coord;
        end
        else
        begin
            held_x_next = held_x_reg;
            held_y_next = held_y_reg;
        end
        result_next.touch_state = pressed;
        result_next.point_x     = held_x_next;
        result_next.point_y     = held_y_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_x_reg <= '0;
            held_y_reg <= '0;
        end
        else if (load)
        begin
            held_x_reg <= held_x_next;
            held_y_reg <= held_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

@@ rtl/core/touch_sample_median_calibrate_top.sv @@
`timescale 1ns / 1ps

// Touch poll median filter and calibrator.
// sample channel: one poll per transfer (pressed flag, four raw X and four
// raw Y conversions), sample_valid / sample_stall.
// point channel: one result per poll (touch_state, point_x, point_y),
// point_valid / point_stall.
// cfg channel: register writes by index, cfg_valid / cfg_ready; cfg_ready is
// always high. Index 7 is ignored. Write only while no poll is in flight.
// A poll passes the sort, multiply and map/saturate registers and the output
// register before it is presented on point. Throughput: one poll per cycle
// while point_stall is low, set by the four-stage pipeline (sort, multiply,
// map/saturate, merge) with one multiplier per axis lane. When point_stall
// is high the output register holds; empty stages ahead of it still fill,
// and sample_stall rises only when stage one cannot move. Reset clears the
// pipeline valids, restores the register defaults and zeroes the held point.
module touch_sample_median_calibrate_top
    import tsmc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  tsmc_in_t              sample,
    output logic                  point_valid,
    input  logic                  point_stall,
    output tsmc_out_t             point,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic signed [GAIN_W-1:0]   gain_x_reg, gain_y_reg;
    logic signed [OFFSET_W-1:0] offset_x_reg, offset_y_reg;
    logic [SAMPLE_W-1:0]        spread_reg;
    logic [REF_W-1:0]           x_ref_reg, y_ref_reg;

    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic p1_reg, p2_reg, p3_reg;
    logic ld_out;
    tsmc_stage_en_t en;

    tsmc_axis_cfg_t cfg_x, cfg_y;
    logic [3:0][SAMPLE_W-1:0] x_samples, y_samples;
    logic signed [POINT_W-1:0] x_coord, y_coord;
    logic x_ok, y_ok;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_x_reg   <= GAIN_X_RESET;
            offset_x_reg <= OFFSET_X_RESET;
            gain_y_reg   <= GAIN_Y_RESET;
            offset_y_reg <= OFFSET_Y_RESET;
            spread_reg   <= SPREAD_RESET;
            x_ref_reg    <= X_REF_RESET;
            y_ref_reg    <= Y_REF_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (tsmc_cfg_idx_t'(cfg_index))
                CFG_GAIN_X:   gain_x_reg   <= cfg_data[GAIN_W-1:0];
                CFG_OFFSET_X: offset_x_reg <= cfg_data[OFFSET_W-1:0];
                CFG_GAIN_Y:   gain_y_reg   <= cfg_data[GAIN_W-1:0];
                CFG_OFFSET_Y: offset_y_reg <= cfg_data[OFFSET_W-1:0];
                CFG_SPREAD:   spread_reg   <= cfg_data[SAMPLE_W-1:0];
                CFG_X_REF:    x_ref_reg    <= cfg_data[REF_W-1:0];
                CFG_Y_REF:    y_ref_reg    <= cfg_data[REF_W-1:0];
                default:      ;
            endcase
        end
    end

    // each stage moves when it is empty or its successor moves
    always_comb
    begin
        ld_out       = v3_reg && (!vo_reg || !point_stall);
        en.s3        = v2_reg && (!v3_reg || ld_out);
        en.s2        = v1_reg && (!v2_reg || en.s3);
        sample_stall = v1_reg && !en.s2;
        en.s1        = sample_valid && !sample_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (en.s1)
                v1_reg <= 1'b1;
            else if (en.s2)
                v1_reg <= 1'b0;
            if (en.s2)
                v2_reg <= 1'b1;
            else if (en.s3)
                v2_reg <= 1'b0;
            if (en.s3)
                v3_reg <= 1'b1;
            else if (ld_out)
                v3_reg <= 1'b0;
            if (ld_out)
                vo_reg <= 1'b1;
            else if (!point_stall)
                vo_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
            p1_reg <= sample.pressed;
        if (en.s2)
            p2_reg <= p1_reg;
        if (en.s3)
            p3_reg <= p2_reg;
    end

    always_comb
    begin
        cfg_x.gain      = gain_x_reg;
        cfg_x.offset    = offset_x_reg;
        cfg_x.reference = x_ref_reg;
        cfg_y.gain      = gain_y_reg;
        cfg_y.offset    = offset_y_reg;
        cfg_y.reference = y_ref_reg;
        x_samples = {sample.x_sample_d, sample.x_sample_c, sample.x_sample_b, sample.x_sample_a};
        y_samples = {sample.y_sample_d, sample.y_sample_c, sample.y_sample_b, sample.y_sample_a};
    end

    tsmc_axis_lane u_lane_x
    (
        .clk          (clk),
        .en           (en),
        .samples      (x_samples),
        .spread_limit (spread_reg),
        .cfg          (cfg_x),
        .coord        (x_coord),
        .ok           (x_ok)
    );

    tsmc_axis_lane u_lane_y
    (
        .clk          (clk),
        .en           (en),
        .samples      (y_samples),
        .spread_limit (spread_reg),
        .cfg          (cfg_y),
        .coord        (y_coord),
        .ok           (y_ok)
    );

    tsmc_merge u_merge
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (ld_out),
        .pressed (p3_reg),
        .x_coord (x_coord),
        .x_ok    (x_ok),
        .y_coord (y_coord),
        .y_ok    (y_ok),
        .result  (point)
    );

    assign point_valid = vo_reg;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import tsmc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_PER_PHASE = 360;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_stall;
    tsmc_in_t              poll_bus = '0;
    logic                  point_valid;
    logic                  point_stall = 1'b0;
    tsmc_out_t             point_bus;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // calibration registers as the predictor sees them
    logic signed [GAIN_W-1:0]   cal_gain_x   = GAIN_X_RESET;
    logic signed [OFFSET_W-1:0] cal_offset_x = OFFSET_X_RESET;
    logic signed [GAIN_W-1:0]   cal_gain_y   = GAIN_Y_RESET;
    logic signed [OFFSET_W-1:0] cal_offset_y = OFFSET_Y_RESET;
    logic [SAMPLE_W-1:0]        cal_spread   = SPREAD_RESET;
    logic [REF_W-1:0]           cal_x_ref    = X_REF_RESET;
    logic [REF_W-1:0]           cal_y_ref    = Y_REF_RESET;
    logic signed [POINT_W-1:0]  held_x = '0;
    logic signed [POINT_W-1:0]  held_y = '0;

    tsmc_in_t  poll_queue[$];
    tsmc_out_t point_due[$];
    tsmc_out_t point_want;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req_cnt = 0;
    int hold_taken = 0;
    int hold_left = 0;
    int fail_count = 0;
    int idle_cycles = 0;

    touch_sample_median_calibrate_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (poll_bus),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point        (point_bus),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_GAIN_X:   cal_gain_x   = value[GAIN_W-1:0];
            CFG_OFFSET_X: cal_offset_x = value[OFFSET_W-1:0];
            CFG_GAIN_Y:   cal_gain_y   = value[GAIN_W-1:0];
            CFG_OFFSET_Y: cal_offset_y = value[OFFSET_W-1:0];
            CFG_SPREAD:   cal_spread   = value[SAMPLE_W-1:0];
            CFG_X_REF:    cal_x_ref    = value[REF_W-1:0];
            CFG_Y_REF:    cal_y_ref    = value[REF_W-1:0];
            default:      ;
        endcase
    endfunction

    function automatic void middle_pair(input logic [SAMPLE_W-1:0] a, b, c, d,
                                        output logic [SAMPLE_W-1:0] lo, hi);
        logic [SAMPLE_W-1:0] v[4];
        logic [SAMPLE_W-1:0] t;
        v[0] = a;
        v[1] = b;
        v[2] = c;
        v[3] = d;
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (v[j] > v[j+1])
                begin
                    t = v[j];
                    v[j] = v[j+1];
                    v[j+1] = t;
                end
            end
        end
        lo = v[1];
        hi = v[2];
    endfunction

    function automatic bit pair_usable(input logic [SAMPLE_W-1:0] lo, hi);
        return lo != '0 && hi != '0 && (hi - lo) <= cal_spread;
    endfunction

    // ref - (sum*gain/2 + offset) in Q16, truncated toward zero, saturated
    function automatic logic signed [POINT_W-1:0] calibrate(
        input logic [SAMPLE_W-1:0] lo, hi,
        input logic signed [GAIN_W-1:0] gain,
        input logic signed [OFFSET_W-1:0] offset,
        input logic [REF_W-1:0] reference);
        longint sum, term, diff, quot;
        sum  = longint'(lo) + longint'(hi);
        term = sum * longint'(gain) + 2 * longint'(offset);
        diff = (longint'(reference) <<< FRAC_W) - term;
        quot = diff / (longint'(1) <<< FRAC_W);
        if (quot > 32767)
            quot = 32767;
        if (quot < -32768)
            quot = -32768;
        return POINT_W'(quot);
    endfunction

    function automatic tsmc_out_t predict_point(input tsmc_in_t poll);
        tsmc_out_t r;
        logic [SAMPLE_W-1:0] xlo, xhi, ylo, yhi;
        if (poll.pressed)
        begin
            middle_pair(poll.x_sample_a, poll.x_sample_b, poll.x_sample_c,
                        poll.x_sample_d, xlo, xhi);
            middle_pair(poll.y_sample_a, poll.y_sample_b, poll.y_sample_c,
                        poll.y_sample_d, ylo, yhi);
            if (pair_usable(xlo, xhi) && pair_usable(ylo, yhi))
            begin
                held_x = calibrate(xlo, xhi, cal_gain_x, cal_offset_x, cal_x_ref);
                held_y = calibrate(ylo, yhi, cal_gain_y, cal_offset_y, cal_y_ref);
            end
        end
        r.touch_state = poll.pressed;
        r.point_x = held_x;
        r.point_y = held_y;
        return r;
    endfunction

    function automatic tsmc_in_t mk_poll(input int p, xa, xb, xc, xd, ya, yb, yc, yd);
        tsmc_in_t r;
        r.pressed    = 1'(p);
        r.x_sample_a = SAMPLE_W'(xa);
        r.x_sample_b = SAMPLE_W'(xb);
        r.x_sample_c = SAMPLE_W'(xc);
        r.x_sample_d = SAMPLE_W'(xd);
        r.y_sample_a = SAMPLE_W'(ya);
        r.y_sample_b = SAMPLE_W'(yb);
        r.y_sample_c = SAMPLE_W'(yc);
        r.y_sample_d = SAMPLE_W'(yd);
        return r;
    endfunction

    // four samples clustered within the current spread limit
    function automatic logic [4*SAMPLE_W-1:0] tight_axis();
        logic [4*SAMPLE_W-1:0] s;
        int base, w;
        base = $urandom_range(8191, 1);
        w = int'(cal_spread);
        if (w > 8191 - base)
            w = 8191 - base;
        for (int i = 0; i < 4; i++)
            s[i*SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(base + int'($urandom_range(w, 0)));
        return s;
    endfunction

    // two low and two high samples with the middle pair just past the limit, or two zeros
    function automatic logic [4*SAMPLE_W-1:0] broken_axis();
        int a, gap;
        a = $urandom_range(4000, 1);
        gap = int'(cal_spread) + 1 + int'($urandom_range(50, 0));
        if ($urandom_range(1) == 0 || a + gap > 8191)
            return {SAMPLE_W'(a), SAMPLE_W'(0), SAMPLE_W'(0), SAMPLE_W'($urandom())};
        return {SAMPLE_W'(a + gap), SAMPLE_W'(a), SAMPLE_W'(a + gap), SAMPLE_W'(a)};
    endfunction

    function automatic tsmc_in_t random_poll();
        tsmc_in_t p;
        int kind;
        kind = $urandom_range(99);
        p = mk_poll(1, $urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom(), $urandom(), $urandom(), $urandom());
        if (kind < 15)
            p.pressed = 1'b0;
        else if (kind < 70)
        begin
            {p.x_sample_a, p.x_sample_b, p.x_sample_c, p.x_sample_d} = tight_axis();
            {p.y_sample_a, p.y_sample_b, p.y_sample_c, p.y_sample_d} = tight_axis();
        end
        else if (kind < 85)
            p.pressed = 1'b1;
        else
        begin
            {p.x_sample_a, p.x_sample_b, p.x_sample_c, p.x_sample_d} = tight_axis();
            {p.y_sample_a, p.y_sample_b, p.y_sample_c, p.y_sample_d} = tight_axis();
            if (kind < 93)
                {p.x_sample_a, p.x_sample_b, p.x_sample_c, p.x_sample_d} = broken_axis();
            else
                {p.y_sample_a, p.y_sample_b, p.y_sample_c, p.y_sample_d} = broken_axis();
        end
        return p;
    endfunction

    // poll sender
    always @(posedge clk)
    begin
        if (!rst_n)
            sample_valid <= 1'b0;
        else
        begin
            if (sample_valid && !sample_stall)
                point_due.push_back(predict_point(poll_bus));
            if (!sample_valid || !sample_stall)
            begin
                if (poll_queue.size() != 0 && int'($urandom_range(99)) >= send_idle_pct)
                begin
                    poll_bus <= poll_queue.pop_front();
                    sample_valid <= 1'b1;
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // point receiver and checker
    always @(posedge clk)
    begin
        if (!rst_n)
            point_stall <= 1'b0;
        else
        begin
            if (point_valid && !point_stall)
            begin
                if (point_due.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected point transfer: state=%0b x=%0d y=%0d",
                                 point_bus.touch_state, point_bus.point_x,
                                 point_bus.point_y);
                    fail_count++;
                end
                else
                begin
                    point_want = point_due.pop_front();
                    if (point_bus.touch_state !== point_want.touch_state ||
                        point_bus.point_x !== point_want.point_x ||
                        point_bus.point_y !== point_want.point_y)
                    begin
                        if (fail_count < 10)
                            $display("point mismatch: exp state=%0b x=%0d y=%0d, got state=%0b x=%0d y=%0d",
                                     point_want.touch_state, point_want.point_x,
                                     point_want.point_y, point_bus.touch_state,
                                     point_bus.point_x, point_bus.point_y);
                        fail_count++;
                    end
                end
            end
            if (hold_left != 0)
            begin
                point_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (hold_taken != hold_req_cnt)
            begin
                hold_taken <= hold_req_cnt;
                hold_left <= HOLD_CYCLES;
                point_stall <= 1'b1;
            end
            else
                point_stall <= int'($urandom_range(99)) < recv_stall_pct;
        end
    end

    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (point_valid && !point_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic wait_drained();
        do
            @(negedge clk);
        while (poll_queue.size() != 0 || point_due.size() != 0 || sample_valid);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        apply_reg(idx, value);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] gx, ox, gy, oy, sp, xr, yr);
        write_reg(CFG_GAIN_X, gx);
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_GAIN_Y, gy);
        write_reg(CFG_OFFSET_Y, oy);
        write_reg(CFG_SPREAD, sp);
        write_reg(CFG_X_REF, xr);
        write_reg(CFG_Y_REF, yr);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input bit with_hold);
        @(negedge clk);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        if (with_hold)
            hold_req_cnt++;
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            poll_queue.push_back(random_poll());
        wait_drained();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        poll_queue.push_back(mk_poll(0, 0, 0, 0, 0, 0, 0, 0, 0));
        poll_queue.push_back(mk_poll(0, 8191, 8191, 8191, 8191, 8191, 8191, 8191, 8191));
        poll_queue.push_back(mk_poll(1, 0, 0, 0, 0, 0, 0, 0, 0));
        poll_queue.push_back(mk_poll(1, 8191, 8191, 8191, 8191, 8191, 8191, 8191, 8191));
        poll_queue.push_back(mk_poll(0, 1, 2, 3, 4, 5, 6, 7, 8));
        poll_queue.push_back(mk_poll(1, 1, 1, 1, 1, 1, 1, 1, 1));
        poll_queue.push_back(mk_poll(1, 2010, 1990, 2000, 1995, 3050, 2950, 3010, 3000));
        poll_queue.push_back(mk_poll(1, 8191, 1100, 0, 1000, 500, 500, 500, 500));
        poll_queue.push_back(mk_poll(1, 8191, 1101, 0, 1000, 700, 700, 700, 700));
        poll_queue.push_back(mk_poll(1, 4000, 4000, 4000, 4000, 0, 5, 0, 8191));
        poll_queue.push_back(mk_poll(1, 4000, 4010, 4005, 4001, 100, 300, 6000, 7000));
        poll_queue.push_back(mk_poll(1, 5461, 2730, 5461, 2730, 2730, 5461, 2730, 5461));
        poll_queue.push_back(mk_poll(1, 5461, 5461, 5461, 5461, 2730, 2730, 2730, 2730));
        poll_queue.push_back(mk_poll(0, 2730, 5461, 2730, 5461, 5461, 2730, 5461, 2730));
        wait_drained();

        write_all(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                  CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                  CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                  CFG_DATA_W'($urandom()));
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
        run_phase(0, 0, 1'b1);

        write_all(CFG_DATA_W'(21'h0FFFFF), CFG_DATA_W'(27'h4000000),
                  CFG_DATA_W'(21'h100000), CFG_DATA_W'(27'h3FFFFFF),
                  CFG_DATA_W'(13'h1FFF), CFG_DATA_W'(12'hFFF), CFG_DATA_W'(12'h000));
        run_phase(62, 0, 1'b0);

        write_all(CFG_DATA_W'(21'h100000), CFG_DATA_W'(27'h3FFFFFF),
                  CFG_DATA_W'(21'h0FFFFF), CFG_DATA_W'(27'h4000000),
                  CFG_DATA_W'(13'h0000), CFG_DATA_W'(12'h000), CFG_DATA_W'(12'hFFF));
        run_phase(0, 62, 1'b0);

        write_all(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                  CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
                  CFG_DATA_W'($urandom_range(400, 0)), CFG_DATA_W'($urandom()),
                  CFG_DATA_W'($urandom()));
        run_phase(10, 10, 1'b0);

        write_all(CFG_DATA_W'(GAIN_X_RESET), CFG_DATA_W'(OFFSET_X_RESET),
                  CFG_DATA_W'(GAIN_Y_RESET), CFG_DATA_W'(OFFSET_Y_RESET),
                  CFG_DATA_W'($urandom_range(300, 1)), CFG_DATA_W'(X_REF_RESET),
                  CFG_DATA_W'(Y_REF_RESET));
        run_phase(0, 0, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (point_due.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/tsmc_pkg.sv
rtl/core/tsmc_sort4.sv
rtl/core/tsmc_axis_lane.sv
rtl/core/tsmc_merge.sv
rtl/core/touch_sample_median_calibrate_top.sv
tb/tb_top.sv
